/* src/nps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg: shared definitions for the next prime search block
// Widths, sequencer control word layout and the microcode program.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CAND_W     = DATA_WIDTH - 1;
  localparam int CNT_W      = $clog2(CAND_W + 1);
  localparam int PC_W       = 4;

  // Largest positive value at DATA_WIDTH bits: all ones over the candidate width.
  localparam logic [CAND_W-1:0] MAX_POS = '1;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SET_D2,
    OP_DIV_START,
    OP_INC_D,
    OP_INC_C,
    OP_SET_C2,
    OP_PUT
  } op_t;

  typedef enum logic [3:0] {
    CD_NEVER,
    CD_ALWAYS,
    CD_NO_INPUT,
    CD_TRIVIAL,
    CD_DIV_BUSY,
    CD_Q_LT_D,
    CD_R_NZERO,
    CD_C_MAX,
    CD_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic              busy;
    logic [CAND_W-1:0] quotient;
    logic [CAND_W-1:0] remainder;
  } div_stat_t;

  // Step addresses of the program.
  localparam pc_t ST_IDLE   = 4'd0;
  localparam pc_t ST_CHECK  = 4'd1;
  localparam pc_t ST_SETD2  = 4'd2;
  localparam pc_t ST_DSTART = 4'd3;
  localparam pc_t ST_DWAIT  = 4'd4;
  localparam pc_t ST_TEST   = 4'd5;
  localparam pc_t ST_STEPD  = 4'd6;
  localparam pc_t ST_CMAX   = 4'd7;
  localparam pc_t ST_INCC   = 4'd8;
  localparam pc_t ST_SET2   = 4'd9;
  localparam pc_t ST_WAITO  = 4'd10;
  localparam pc_t ST_EMIT   = 4'd11;

  // When the condition holds the sequencer jumps to target, else it falls through.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      ST_IDLE:   w = '{op: OP_LOAD,      cond: CD_NO_INPUT,  target: ST_IDLE};
      ST_CHECK:  w = '{op: OP_NOP,       cond: CD_TRIVIAL,   target: ST_SET2};
      ST_SETD2:  w = '{op: OP_SET_D2,    cond: CD_NEVER,     target: ST_IDLE};
      ST_DSTART: w = '{op: OP_DIV_START, cond: CD_NEVER,     target: ST_IDLE};
      ST_DWAIT:  w = '{op: OP_NOP,       cond: CD_DIV_BUSY,  target: ST_DWAIT};
      ST_TEST:   w = '{op: OP_NOP,       cond: CD_Q_LT_D,    target: ST_WAITO};
      ST_STEPD:  w = '{op: OP_INC_D,     cond: CD_R_NZERO,   target: ST_DSTART};
      ST_CMAX:   w = '{op: OP_NOP,       cond: CD_C_MAX,     target: ST_WAITO};
      ST_INCC:   w = '{op: OP_INC_C,     cond: CD_ALWAYS,    target: ST_SETD2};
      ST_SET2:   w = '{op: OP_SET_C2,    cond: CD_NEVER,     target: ST_IDLE};
      ST_WAITO:  w = '{op: OP_NOP,       cond: CD_OUT_FULL,  target: ST_WAITO};
      ST_EMIT:   w = '{op: OP_PUT,       cond: CD_ALWAYS,    target: ST_IDLE};
      default:   w = '{op: OP_NOP,       cond: CD_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* src/nps_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_if: valid/ready channels of the next prime search block
// One interface for start values coming in and one for primes going out.
// ----------------------------------------------------------------------------
interface nps_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [nps_pkg::DATA_WIDTH-1:0]  start_value;

  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

interface nps_out_if;
  logic                           valid;
  logic                           ready;
  logic [nps_pkg::CAND_W-1:0]     next_prime;

  modport source (output valid, output next_prime, input ready);
  modport sink   (input valid, input next_prime, output ready);
endinterface
`default_nettype wire

/* src/nps_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nps_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nps_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [nps_pkg::CAND_W-1:0] dividend,
  input  wire logic [nps_pkg::CAND_W-1:0] divisor,
  output nps_pkg::div_stat_t              stat
);

  logic [nps_pkg::CAND_W-1:0] rem_r, rem_nxt;
  logic [nps_pkg::CAND_W-1:0] quo_r, quo_nxt;
  logic [nps_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [nps_pkg::CAND_W:0]   trial;
  logic [nps_pkg::CAND_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[nps_pkg::CAND_W-1]};
    diff     = trial - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = nps_pkg::CNT_W'(nps_pkg::CAND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the difference fits back in.
      if (!diff[nps_pkg::CAND_W]) begin
        rem_nxt = diff[nps_pkg::CAND_W-1:0];
        quo_nxt = {quo_r[nps_pkg::CAND_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[nps_pkg::CAND_W-1:0];
        quo_nxt = {quo_r[nps_pkg::CAND_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != nps_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.quotient  = quo_r;
  assign stat.remainder = rem_r;

endmodule
`default_nettype wire

/* src/next_prime_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_prime_search: smallest prime at or above a signed start value
//
// The input channel carries one signed start value per beat; the output
// channel returns one beat per input beat holding the smallest prime that is
// at or above that value. Start values that are negative, zero, one or two
// skip the search: the sequencer passes through its check, set-to-two,
// output-wait and emit steps, and ready returns as the output valid rises.
// Otherwise each candidate is tested by trial division with divisors 2, 3,
// 4 and so on until either a divisor divides it (the next candidate is
// tried) or the divisor exceeds the quotient (the candidate is prime). Each
// trial divisor takes one full run of the one-bit-per-cycle divider; a prime
// near the top of the range needs about 46340 divisors, and a composite
// candidate stops at its smallest factor. One item is worked on at a time;
// ready is high only while the sequencer sits at its idle step. The result
// is held in an output register; while the receiver stalls the sequencer
// can take and search a new beat but waits with its finished result until
// the register has been emptied. Reset returns the sequencer to idle and
// drops the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module next_prime_search (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nps_in_if.sink     in_ch,
  nps_out_if.source  out_ch
);

  // Sequencer state: a step counter addressing the microcode table.
  nps_pkg::pc_t    pc_r, pc_nxt;
  nps_pkg::uword_t uw;
  logic            cond_true;

  // Datapath: candidate, its sign, trial divisor and the output register.
  logic [nps_pkg::CAND_W-1:0] c_r, c_nxt;
  logic                       neg_r, neg_nxt;
  logic [nps_pkg::CAND_W-1:0] d_r, d_nxt;
  logic [nps_pkg::CAND_W-1:0] res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       div_start;
  nps_pkg::div_stat_t         div_stat;

  nps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (c_r),
    .divisor  (d_r),
    .stat     (div_stat)
  );

  assign in_ch.ready       = (pc_r == nps_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_prime = res_r;

  always_comb begin
    uw = nps_pkg::ucode(pc_r);

    // Branch condition selected by the control word.
    unique case (uw.cond)
      nps_pkg::CD_NEVER:    cond_true = 1'b0;
      nps_pkg::CD_ALWAYS:   cond_true = 1'b1;
      nps_pkg::CD_NO_INPUT: cond_true = !in_ch.valid;
      nps_pkg::CD_TRIVIAL:  cond_true = neg_r || (c_r <= nps_pkg::CAND_W'(2));
      nps_pkg::CD_DIV_BUSY: cond_true = div_stat.busy;
      // Divisor beyond the quotient means no factor is left to try.
      nps_pkg::CD_Q_LT_D:   cond_true = (div_stat.quotient < d_r);
      nps_pkg::CD_R_NZERO:  cond_true = (div_stat.remainder != '0);
      nps_pkg::CD_C_MAX:    cond_true = (c_r == nps_pkg::MAX_POS);
      nps_pkg::CD_OUT_FULL: cond_true = out_valid_r;
      default:              cond_true = 1'b1;
    endcase
    pc_nxt = cond_true ? uw.target : pc_r + 1'b1;

    c_nxt         = c_r;
    neg_nxt       = neg_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    div_start     = 1'b0;

    unique case (uw.op)
      nps_pkg::OP_NOP:       ;
      // The idle step samples the channel every cycle; the accepted beat stays.
      nps_pkg::OP_LOAD: begin
        c_nxt   = in_ch.start_value[nps_pkg::CAND_W-1:0];
        neg_nxt = in_ch.start_value[nps_pkg::DATA_WIDTH-1];
      end
      nps_pkg::OP_SET_D2:    d_nxt = nps_pkg::CAND_W'(2);
      nps_pkg::OP_DIV_START: div_start = 1'b1;
      nps_pkg::OP_INC_D:     d_nxt = d_r + 1'b1;
      nps_pkg::OP_INC_C:     c_nxt = c_r + 1'b1;
      nps_pkg::OP_SET_C2:    c_nxt = nps_pkg::CAND_W'(2);
      nps_pkg::OP_PUT: begin
        res_nxt       = c_r;
        out_valid_nxt = 1'b1;
      end
      default:               ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= nps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r   <= c_nxt;
    neg_r <= neg_nxt;
    d_r   <= d_nxt;
    res_r <= res_nxt;
  end

  // An accepted beat always moves the sequencer to its classification step.
  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (pc_r == nps_pkg::ST_CHECK))
    else $error("accepted beat did not start the search");

  // The output register is never overwritten while it still holds a result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == nps_pkg::ST_EMIT) |-> !out_valid_r)
    else $error("result written over a pending beat");

  // The divider only runs while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (pc_r == nps_pkg::ST_DWAIT))
    else $error("divider busy outside its wait step");

  // Every delivered result is at least two.
  a_res_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r >= nps_pkg::CAND_W'(2)))
    else $error("result below two");

endmodule
`default_nettype wire

/* test/next_prime_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_search_tb: self-checking bench for the next prime search block
//
// Start values go in one beat at a time over the valid/ready input channel.
// For each accepted beat the bench queues the smallest prime at or above
// the value, typed in for some directed rows and else found by its own
// trial division search. Every beat on the result channel is checked against
// the oldest queued prime. A short table of directed values runs first,
// followed by random values under four idling patterns of sender and receiver.
// ----------------------------------------------------------------------------
module next_prime_search_tb;

  localparam int RANDOM_PER_PHASE = 25;
  localparam int NUM_PHASES       = 4;
  localparam int DRAIN_CYCLES     = 50;

  // One row of the directed table. Where has_answer is set the expected prime
  // is typed in; otherwise it comes from the bench's own search.
  typedef struct {
    logic signed [nps_pkg::DATA_WIDTH-1:0] start_value;
    bit                                    has_answer;
    logic        [nps_pkg::CAND_W-1:0]     answer;
  } start_row_t;

  localparam int NUM_DIRECTED = 24;

  start_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    // Negative starts return 2 at once, the most negative value included.
    '{-32'sd2147483648, 1'b1, 31'd2},
    '{-32'sd1,          1'b1, 31'd2},
    '{-32'sd1073741824, 1'b1, 31'd2},
    // Zero, one and two all return 2.
    '{32'sd0,           1'b1, 31'd2},
    '{32'sd1,           1'b1, 31'd2},
    '{32'sd2,           1'b1, 31'd2},
    // Smallest values that take the search path.
    '{32'sd3,           1'b1, 31'd3},
    '{32'sd4,           1'b1, 31'd5},
    // Largest positive start: it is prime itself, so the search ends there.
    '{32'sd2147483647,  1'b1, 31'd2147483647},
    // Squares of primes, and starts that lead up to them, probe where the divisor meets the quotient.
    '{32'sd8,           1'b0, 31'd0},
    '{32'sd9,           1'b0, 31'd0},
    '{32'sd24,          1'b0, 31'd0},
    '{32'sd25,          1'b0, 31'd0},
    '{32'sd49,          1'b0, 31'd0},
    '{32'sd121,         1'b0, 31'd0},
    '{32'sd961,         1'b0, 31'd0},
    // Prime starts, starts inside runs of composites before the next prime, and larger values.
    '{32'sd89,          1'b0, 31'd0},
    '{32'sd90,          1'b0, 31'd0},
    '{32'sd114,         1'b0, 31'd0},
    '{32'sd1000,        1'b0, 31'd0},
    '{32'sd7919,        1'b0, 31'd0},
    '{32'sd32768,       1'b0, 31'd0},
    '{32'sd65536,       1'b0, 31'd0},
    '{32'sd1000000,     1'b0, 31'd0}
  };

  logic clk;
  logic rst_n;

  nps_in_if  in_bus ();
  nps_out_if out_bus ();

  next_prime_search uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Primes expected on the result channel, oldest first.
  logic [nps_pkg::CAND_W-1:0] pending_primes [$];
  int                         mismatch_count = 0;

  // Idling controls, in percent of cycles; changed between phases.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  always #2 clk = ~clk;

  // Trial division with divisors 2, 3, 4 and so on while the divisor is
  // no larger than the candidate divided by it.
  function automatic bit has_no_factor(input longint cand);
    longint d;
    if (cand < 2) return 1'b0;
    for (d = 2; d <= cand / d; d++) begin
      if (cand % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Smallest prime at or above a signed start value. Anything negative or
  // at most two gives 2. If no prime lies below the largest positive value
  // the search stops there and returns it.
  function automatic logic [nps_pkg::CAND_W-1:0] smallest_prime_from(
    input logic signed [nps_pkg::DATA_WIDTH-1:0] start
  );
    longint top;
    longint cand;
    top = (longint'(1) << nps_pkg::CAND_W) - 1;
    if (start[nps_pkg::DATA_WIDTH-1] || start <= 2) return nps_pkg::CAND_W'(2);
    for (cand = longint'(start); cand <= top; cand++) begin
      if (has_no_factor(cand)) return cand[nps_pkg::CAND_W-1:0];
    end
    return top[nps_pkg::CAND_W-1:0];
  endfunction

  // Random start values. Most are small so the divider loop stays short;
  // negative values carry fully random lower bits so that every bit of the
  // field is seen at both levels without paying for huge searches.
  function automatic logic signed [nps_pkg::DATA_WIDTH-1:0] random_start();
    logic signed [nps_pkg::DATA_WIDTH-1:0] v;
    int                                    pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      v = $urandom;
      v[nps_pkg::DATA_WIDTH-1] = 1'b1;
    end else if (pick < 25) begin
      v = $urandom_range(4);
    end else if (pick < 60) begin
      v = $urandom_range(1000);
    end else if (pick < 92) begin
      v = $urandom_range(65536);
    end else begin
      v = $urandom_range(1 << 20);
    end
    return v;
  endfunction

  // Offer one start value and hold it until the block takes the beat. The
  // caller is always just past a rising edge. Valid is only lowered when the
  // sender decides to idle, so it never drops and rises in one time step.
  task automatic send_start(input logic signed [nps_pkg::DATA_WIDTH-1:0] start,
                            input logic        [nps_pkg::CAND_W-1:0]     prime);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.start_value <= start;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    // The beat was accepted at this edge.
    pending_primes.push_back(prime);
  endtask

  // Receiver: checks each result beat against the oldest expected prime and
  // draws a fresh ready every cycle according to the current stall rate.
  initial begin
    logic [nps_pkg::CAND_W-1:0] want;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (pending_primes.size() == 0) begin
          $display("%0t ns: next_prime expected none, got %0d", $time, out_bus.next_prime);
          mismatch_count++;
        end else begin
          want = pending_primes.pop_front();
          if (out_bus.next_prime !== want) begin
            $display("%0t ns: next_prime expected %0d, got %0d",
                     $time, want, out_bus.next_prime);
            mismatch_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    logic signed [nps_pkg::DATA_WIDTH-1:0] start;
    int                                    src_pct  [NUM_PHASES];
    int                                    sink_pct [NUM_PHASES];

    // No idling; sender idle most cycles; receiver stalling most cycles;
    // both idling now and then.
    src_pct  = '{0, 80, 0, 15};
    sink_pct = '{0, 0, 80, 15};

    clk = 1'b0;
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.start_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].has_answer) begin
        send_start(directed_rows[i].start_value, directed_rows[i].answer);
      end else begin
        send_start(directed_rows[i].start_value,
                   smallest_prime_from(directed_rows[i].start_value));
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      src_idle_pct   = src_pct[p];
      sink_stall_pct = sink_pct[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        start = random_start();
        send_start(start, smallest_prime_from(start));
      end
    end
    in_bus.valid <= 1'b0;

    // Let every outstanding result come back, then a little longer so that a
    // stray extra beat would still be caught.
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("next_prime_search: match");
    end else begin
      $display("next_prime_search: mismatch");
    end
    $finish;
  end

  // Watchdog. The largest directed start alone needs about 46340 trial divisors,
  // and the timeout leaves a wide margin over the whole run.
  initial begin
    #100_000_000;
    $display("next_prime_search: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/nps_pkg.sv
src/nps_if.sv
src/nps_div.sv
src/next_prime_search.sv
test/next_prime_search_tb.sv
